>>> src/sis_pkg.sv
package sis_pkg;

  localparam int NUM_CLASSES = 3;

  typedef enum logic [1:0] {
    CLS_BATCH   = 2'd0,
    CLS_INSTANT = 2'd1,
    CLS_WAITED  = 2'd2,
    CLS_BAD     = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    cls_e cls;
  } cell_ctl_t;

endpackage

>>> src/sis_cell.sv
module sis_cell #(
  parameter int IDX         = 0,
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  logic                                 clk_i,
  input  sis_pkg::cell_ctl_t                   ctl_i,
  input  logic [ID_BITS-1:0]                   id_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     sel_count_i,
  input  logic [ID_BITS-1:0]                   left_entry_i,
  input  logic                                 left_lt_i,
  output logic [ID_BITS-1:0]                   entry_o,
  output logic                                 lt_o,
  output logic                                 eq_o,
  output logic                                 here_o
);
  import sis_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [ID_BITS-1:0] entry_q [NUM_CLASSES];
  logic               occupied;

  always_comb begin
    case (ctl_i.cls)
      CLS_BATCH:   entry_o = entry_q[0];
      CLS_INSTANT: entry_o = entry_q[1];
      CLS_WAITED:  entry_o = entry_q[2];
      default:     entry_o = '0;
    endcase
  end

  assign occupied = MY_IDX < sel_count_i;
  assign lt_o     = occupied && (entry_o < id_i);
  assign eq_o     = occupied && (entry_o == id_i);
  // Sorted prefix of smaller entries ends here
  assign here_o   = left_lt_i && !lt_o;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (ctl_i.ins && (ctl_i.cls == cls_e'(c))) begin
        if (here_o) begin
          entry_q[c] <= id_i;
        end else if (!left_lt_i) begin
          // shift up: take the neighbor's entry
          entry_q[c] <= left_entry_i;
        end
      end
    end
  end

endmodule

>>> src/sorted_id_set_insert.sv
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   list_select_i, entry_id_i
// out      source     out_valid_o / out_stall_i status_o, list_count_o, insert_position_o
//
// One transaction per cycle while the input is not stalled: the row of cells compares,
// checks for a duplicate and shifts in the same cycle the input is taken; the result
// is registered. Reset clears the counts and the output valid flag; the table
// entries are not cleared and are read only below a class count.
// Input stalls only while a result is held and the output is stalled.
module sorted_id_set_insert #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  list_select_i,
  input  logic [15:0] entry_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  list_count_o,
  output logic [5:0]  insert_position_o
);
  import sis_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  logic               accept;
  cls_e               cls;
  logic [47:0]        id_ext;
  logic [ID_BITS-1:0] id;
  logic [CW-1:0]      count_q [NUM_CLASSES];
  logic [CW-1:0]      sel_count;
  logic               dup;
  logic               full;
  logic               do_ins;
  cell_ctl_t          ctl;
  logic [PW-1:0]      pos;
  logic [CW-1:0]      new_count;
  status_e            status;

  logic [ID_BITS-1:0] entry   [TABLE_DEPTH];
  logic [ID_BITS-1:0] left_e  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt, eq, here, left_lt;

  logic          out_valid_q;
  status_e       status_q;
  logic [CW-1:0] out_count_q;
  logic [PW-1:0] pos_q;
  logic [CW+6:0] count_ext;
  logic [PW+5:0] pos_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cls        = cls_e'(list_select_i);
  assign id_ext     = {32'b0, entry_id_i};
  assign id         = id_ext[ID_BITS-1:0];

  always_comb begin
    case (cls)
      CLS_BATCH:   sel_count = count_q[0];
      CLS_INSTANT: sel_count = count_q[1];
      CLS_WAITED:  sel_count = count_q[2];
      default:     sel_count = '0;
    endcase
  end

  assign ctl.cls = cls;
  assign ctl.ins = do_ins;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_lt[i] = 1'b1;
      assign left_e[i]  = id;
    end else begin : g_link
      assign left_lt[i] = lt[i-1];
      assign left_e[i]  = entry[i-1];
    end

    sis_cell #(
      .IDX        (i),
      .TABLE_DEPTH(TABLE_DEPTH),
      .ID_BITS    (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .id_i        (id),
      .sel_count_i (sel_count),
      .left_entry_i(left_e[i]),
      .left_lt_i   (left_lt[i]),
      .entry_o     (entry[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i]),
      .here_o      (here[i])
    );
  end

  // here is one-hot unless the table is full and every held entry is smaller
  always_comb begin
    pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pos = pos | (here[i] ? PW'(i) : '0);
    end
  end

  assign dup    = |eq;
  assign full   = sel_count == FULL_COUNT;
  assign do_ins = accept && (cls != CLS_BAD) && !dup && !full;

  always_comb begin
    new_count = sel_count;
    if (cls == CLS_BAD) begin
      status = ST_BAD_CLASS;
    end else if (dup) begin
      status = ST_DUPLICATE;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status    = ST_INSERTED;
      new_count = sel_count + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        count_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (do_ins && (cls == cls_e'(c))) begin
          count_q[c] <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result while the output is stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status;
      out_count_q <= new_count;
      pos_q       <= (status == ST_INSERTED) ? pos : '0;
    end
  end

  assign count_ext = {7'b0, out_count_q};
  assign pos_ext   = {6'b0, pos_q};

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign list_count_o      = count_ext[6:0];
  assign insert_position_o = pos_ext[5:0];

endmodule

>>> tb/sorted_id_set_insert_tb.sv
module sorted_id_set_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sis_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 930;
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 550;
  localparam int HOLDOFF_AT   = 700;
  localparam int HOLDOFF_LEN  = 150;
  localparam int STALL_PCT    = 37;
  localparam int WATCHDOG_MAX = 2000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct {
    cls_e        cls;
    logic [15:0] id;
    bit          drain;  // hold until every awaited result is back
  } id_request_t;

  typedef struct {
    status_e     status;
    logic [6:0]  count;
    logic [5:0]  pos;
  } insert_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  list_select_i;
  logic [15:0] entry_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [6:0]  list_count_o;
  logic [5:0]  insert_position_o;

  id_request_t    id_requests[$];
  insert_result_t awaited_results[$];

  // Shadow copy of the three class tables
  logic [15:0] shadow_ids [NUM_CLASSES][DEPTH];
  int          shadow_count [NUM_CLASSES];

  // Stimulus bookkeeping: ids known to be stored, per class
  logic [15:0] stored_hist [NUM_CLASSES][$];
  logic [15:0] top_id [NUM_CLASSES];
  bit          issued [int];

  int             accepted_in;
  int             mismatches;
  int             quiet_cycles;
  int             holdoff_left;
  bit             holdoff_done;
  insert_result_t got_exp;

  sorted_id_set_insert uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .list_select_i     (list_select_i),
    .entry_id_i        (entry_id_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .list_count_o      (list_count_o),
    .insert_position_o (insert_position_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic bit calm_phase();
    return accepted_in >= CALM_FROM && accepted_in < CALM_TO;
  endfunction

  task automatic predict_insert(input logic [1:0] sel, input logic [15:0] id);
    insert_result_t r;
    int n;
    int i;
    int k;
    r.status = ST_BAD_CLASS;
    r.count  = '0;
    r.pos    = '0;
    if (sel != CLS_BAD) begin
      n = shadow_count[sel];
      i = 0;
      while (i < n && shadow_ids[sel][i] < id) i++;
      if (i < n && shadow_ids[sel][i] == id) begin
        r.status = ST_DUPLICATE;
      end else if (n >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // shift larger entries up by one
        for (k = n; k > i; k--) shadow_ids[sel][k] = shadow_ids[sel][k-1];
        shadow_ids[sel][i] = id;
        shadow_count[sel]  = n + 1;
        r.status = ST_INSERTED;
        r.pos    = 6'(i);
      end
      r.count = 7'(shadow_count[sel]);
    end
    awaited_results.push_back(r);
  endtask

  task automatic queue_request(input cls_e cls, input logic [15:0] id, input bit drain);
    id_request_t req;
    int key;
    req.cls   = cls;
    req.id    = id;
    req.drain = drain;
    id_requests.push_back(req);
    key = (int'(cls) << 16) | int'(id);
    if (cls != CLS_BAD && !issued.exists(key) && stored_hist[cls].size() < DEPTH) begin
      issued[key] = 1'b1;
      stored_hist[cls].push_back(id);
      if (stored_hist[cls].size() == 1 || id > top_id[cls]) top_id[cls] = id;
    end
  endtask

  // Sender: offer the next pending transaction once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      list_select_i <= CLS_BATCH;
      entry_id_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_insert(list_select_i, entry_id_i);
        accepted_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (id_requests.size() != 0
            && !(id_requests[0].drain && awaited_results.size() != 0)
            && (calm_phase() || $urandom_range(99) >= STALL_PCT)) begin
          in_valid_i    <= 1'b1;
          list_select_i <= id_requests[0].cls;
          entry_id_i    <= id_requests[0].id;
          void'(id_requests.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
    end else if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else if (!holdoff_done && accepted_in >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= !calm_phase() && $urandom_range(99) < STALL_PCT;
    end
  end

  // Monitor: compare each result transaction with the oldest awaited one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result status=%0d count=%0d pos=%0d",
                   $realtime, status_o, list_count_o, insert_position_o);
        mismatches++;
      end else begin
        got_exp = awaited_results.pop_front();
        if (status_o !== got_exp.status || list_count_o !== got_exp.count
            || insert_position_o !== got_exp.pos) begin
          if (mismatches < 10)
            $display("%0t: mismatch expected status=%0d count=%0d pos=%0d, got %0d %0d %0d",
                     $realtime, got_exp.status, got_exp.count, got_exp.pos,
                     status_o, list_count_o, insert_position_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    cls_e        cls;
    logic [15:0] id;
    int          pick;

    accepted_in  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    for (int c = 0; c < NUM_CLASSES; c++) shadow_count[c] = 0;

    // empty table, both ends, shift in the middle, duplicates, bad class
    queue_request(CLS_BATCH,   16'h8000, 1'b0);
    queue_request(CLS_BATCH,   16'h0000, 1'b0);
    queue_request(CLS_BATCH,   16'hffff, 1'b0);
    queue_request(CLS_BATCH,   16'h8000, 1'b0);
    queue_request(CLS_BATCH,   16'h7fff, 1'b0);
    queue_request(CLS_INSTANT, 16'hffff, 1'b0);
    queue_request(CLS_INSTANT, 16'h0000, 1'b0);
    queue_request(CLS_INSTANT, 16'h5555, 1'b0);
    queue_request(CLS_INSTANT, 16'haaaa, 1'b0);
    queue_request(CLS_INSTANT, 16'h0000, 1'b0);
    queue_request(CLS_WAITED,  16'h1234, 1'b0);
    queue_request(CLS_WAITED,  16'h1234, 1'b0);
    queue_request(CLS_WAITED,  16'hedcb, 1'b0);
    queue_request(CLS_BAD,     16'hffff, 1'b0);
    queue_request(CLS_BAD,     16'h0000, 1'b0);
    queue_request(CLS_BAD,     16'h5555, 1'b0);
    queue_request(CLS_WAITED,  16'h0000, 1'b0);

    // Tables fill up early; later traffic hits full tables and duplicates
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cls  = ($urandom_range(99) < 5) ? CLS_BAD : cls_e'($urandom_range(2));
      pick = $urandom_range(99);
      if (cls != CLS_BAD && stored_hist[cls].size() == DEPTH - 1
          && top_id[cls] != 16'hffff && pick < 60) begin
        // last free slot: aim for the top position
        id = 16'($urandom_range(16'hffff, int'(top_id[cls]) + 1));
      end else if (cls != CLS_BAD && stored_hist[cls].size() != 0 && pick < 25) begin
        id = stored_hist[cls][$urandom_range(stored_hist[cls].size() - 1)];
      end else if (pick < 33) begin
        id = pick[0] ? 16'hffff : 16'h0000;
      end else begin
        id = 16'($urandom_range(16'hffff));
      end
      queue_request(cls, id, n == 0 || n == 500);
    end

    wait (rst_ni);
    while (id_requests.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
